// ----- hdl/allocation_bitmap_store_macros.svh -----
// assertion macros of the allocation bitmap store, used by abs_ctrl
`ifndef ALLOCATION_BITMAP_STORE_MACROS_SVH
`define ALLOCATION_BITMAP_STORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ABS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ABS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/abs_pkg.sv -----
// types, constants and helpers of the allocation bitmap store
`timescale 1ns / 1ps

package abs_pkg;

	localparam int MAP_BITS    = 4096;
	localparam int STORE_BYTES = (MAP_BITS + 7) / 8;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	localparam int MAP_SIZE_W   = 13;
	localparam int MAP_SIZE_RST = 4096;
	localparam int LIM_W        = ($clog2(MAP_BITS + 1) < MAP_SIZE_W) ?
		$clog2(MAP_BITS + 1) : MAP_SIZE_W;
	localparam int LIMIT_RST    = (MAP_SIZE_RST < MAP_BITS) ? MAP_SIZE_RST : MAP_BITS;

	localparam int MODE_W   = 3;
	localparam int INDEX_W  = 16;
	localparam int LENGTH_W = 17;
	localparam int CMP_W    = 17;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	localparam logic [MODE_W-1:0] MODE_SET_BIT     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR_BIT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE_BIT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ_BIT    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SET_RANGE   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR_RANGE = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [INDEX_W-1:0]  index;
		logic [LENGTH_W-1:0] length;
		logic                bit_value;
	} req_t;

	typedef struct packed {
		logic status;
		logic read_bit;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] byte_addr(input logic [CMP_W-1:0] pos);
		byte_addr = ADDR_W'(pos >> 3);
	endfunction

endpackage

// ----- hdl/allocation_bitmap_store.sv -----
// Allocation bitmap store: bit and run updates on a byte-wide bitmap.
// Requests enter on the s_ channel: s_tuser carries the operation, s_tdata the
// index, length and write value. Each request gives one word on the m_ channel:
// m_tuser is the reject flag, m_tdata bit 0 the bit read.
// The map size register is written through cfg_wen / cfg_wdata; the user must
// write it only while idle, which the block does not enforce. The active limit
// is the smaller of it and the map capacity. Every access is a byte
// read-modify-write through one ram with one write and one read port: reads are
// issued one byte per cycle and written back in the next cycle. A new request
// is taken as the previous result moves into the output register. After reset
// the ram is cleared one byte a cycle, all 512 bytes at the default size, and
// s_tready stays low until that pass ends. When the receiver stalls the result
// waits in the output register; one more request is worked on and then
// s_tready drops until the output drains.
`timescale 1ns / 1ps

module allocation_bitmap_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [abs_pkg::S_DATA_W-1:0]      s_tdata,  // index, length, bit_value, zero pad
	input  logic [abs_pkg::MODE_W-1:0]        s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [abs_pkg::M_DATA_W-1:0]      m_tdata,  // read_bit, zero pad
	output logic [0:0]                        m_tuser,  // status
	input  logic                              cfg_wen,
	input  logic [abs_pkg::MAP_SIZE_W-1:0]    cfg_wdata
);
	import abs_pkg::*;

	logic [LIM_W-1:0] limit_q;
	logic             out_valid_q;
	res_t             out_q;
	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             slot_free;
	mem_req_t         mem;
	logic [7:0]       mem_rdata;

	assign req.mode      = s_tuser;
	assign req.index     = s_tdata[INDEX_W-1:0];
	assign req.length    = s_tdata[INDEX_W+LENGTH_W-1:INDEX_W];
	assign req.bit_value = s_tdata[INDEX_W+LENGTH_W];

	assign slot_free = !out_valid_q || m_tready;

	// clamp the map size to the capacity once, at the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(LIMIT_RST);
		end else if (cfg_wen) begin
			limit_q <= (CMP_W'(cfg_wdata) < CMP_W'(MAP_BITS)) ?
				LIM_W'(cfg_wdata) : LIM_W'(MAP_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'(out_q.read_bit);
	assign m_tuser  = out_q.status;

	abs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.limit     (limit_q),
		.res_valid (res_valid),
		.res_ready (slot_free),
		.res       (res),
		.mem       (mem),
		.mem_rdata (mem_rdata)
	);

	abs_ram #(
		.WIDTH  (8),
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- hdl/abs_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module abs_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/abs_ctrl.sv -----
// request decoder and byte read-modify-write sequencer of the bitmap store
`timescale 1ns / 1ps
`include "allocation_bitmap_store_macros.svh"

module abs_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  abs_pkg::req_t            req,
	input  logic [abs_pkg::LIM_W-1:0] limit,
	output logic                     res_valid,
	input  logic                     res_ready,
	output abs_pkg::res_t            res,
	output abs_pkg::mem_req_t        mem,
	input  logic [7:0]               mem_rdata
);
	import abs_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] cur_q;
	logic [ADDR_W-1:0] first_q;
	logic [ADDR_W-1:0] last_q;
	logic [2:0]        lo_q;
	logic [2:0]        hi_q;
	logic              val_q;
	logic              rd_op_q;
	logic              status_q;
	logic              rd_q;

	logic              valid_s1;
	logic              wr_s1;
	logic              val_s1;
	logic [2:0]        sel_s1;
	logic [7:0]        mask_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic             accept;
	logic [CMP_W-1:0] idx_x;
	logic [CMP_W-1:0] len_x;
	logic [CMP_W-1:0] lim_x;
	logic [CMP_W-1:0] end_x;
	logic             single_op;
	logic             range_op;
	logic             bit_rej;
	logic             rng_rej;
	logic             go_run;
	logic             dec_val;
	logic             dec_status;
	logic [2:0]       lo_eff;
	logic [2:0]       hi_eff;
	logic [7:0]       mask;
	logic [7:0]       new_byte;
	logic             bit_now;

	assign req_ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && res_ready);
	assign accept    = req_valid && req_ready;

	// request decode
	assign idx_x = CMP_W'(req.index);
	assign len_x = CMP_W'(req.length);
	assign lim_x = CMP_W'(limit);
	assign end_x = idx_x + len_x - CMP_W'(1);

	assign single_op = req.mode < MODE_SET_RANGE;
	assign range_op  = (req.mode == MODE_SET_RANGE) || (req.mode == MODE_CLEAR_RANGE);
	assign bit_rej   = idx_x >= lim_x;
	assign rng_rej   = (idx_x > lim_x) || (len_x > (lim_x - idx_x));
	assign go_run    = (single_op && !bit_rej) || (range_op && !rng_rej && (len_x != '0));
	assign dec_status = (single_op && bit_rej) || (range_op && rng_rej);

	always_comb begin
		unique case (req.mode)
			MODE_SET_BIT:   dec_val = 1'b1;
			MODE_WRITE_BIT: dec_val = req.bit_value;
			MODE_SET_RANGE: dec_val = 1'b1;
			default:        dec_val = 1'b0;
		endcase
	end

	// mask of the run within the current byte
	assign lo_eff = (cur_q == first_q) ? lo_q : 3'd0;
	assign hi_eff = (cur_q == last_q) ? hi_q : 3'd7;
	assign mask   = (8'hFF << lo_eff) & (8'hFF >> (3'd7 - hi_eff));

	assign new_byte = val_s1 ? (mem_rdata | mask_s1) : (mem_rdata & ~mask_s1);
	assign bit_now  = mem_rdata[sel_s1];

	assign mem.we    = (state_q == ST_CLEAR) || (valid_s1 && wr_s1);
	assign mem.waddr = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign mem.wdata = (state_q == ST_CLEAR) ? 8'h00 : new_byte;
	assign mem.raddr = cur_q;

	assign res_valid    = state_q == ST_FIN;
	assign res.status   = status_q;
	assign res.read_bit = rd_op_q && (valid_s1 ? bit_now : rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_RUN;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (cur_q == last_q) begin
						state_q <= ST_FIN;
					end
				end
				default: begin
					if (accept) begin
						state_q <= go_run ? ST_RUN : ST_FIN;
					end else if ((state_q == ST_FIN) && res_ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !wr_s1) begin
			rd_q <= bit_now;
		end
		priority if (accept) begin
			first_q  <= byte_addr(idx_x);
			cur_q    <= byte_addr(idx_x);
			last_q   <= single_op ? byte_addr(idx_x) : byte_addr(end_x);
			lo_q     <= req.index[2:0];
			hi_q     <= single_op ? req.index[2:0] : end_x[2:0];
			val_q    <= dec_val;
			rd_op_q  <= (req.mode == MODE_READ_BIT) && !bit_rej;
			status_q <= dec_status;
		end else if (state_q == ST_RUN) begin
			cur_q   <= cur_q + ADDR_W'(1);
			addr_s1 <= cur_q;
			mask_s1 <= mask;
			wr_s1   <= !rd_op_q;
			val_s1  <= val_q;
			sel_s1  <= lo_q;
		end
	end

	`ABS_ASSERT_NOW(a_no_raw_overlap, (state_q == ST_RUN) && valid_s1 && wr_s1,
		addr_s1 != cur_q, "write back and read hit the same byte")
	`ABS_ASSERT_NEXT(a_accept_moves_on, accept,
		(state_q == ST_RUN) || (state_q == ST_FIN), "accepted word left the sequencer idle")
	`ABS_ASSERT_NOW(a_walk_in_bounds, state_q == ST_RUN, cur_q <= last_q,
		"byte walk passed the last byte")
	`ABS_ASSERT_NEXT(a_read_feeds_s1, state_q == ST_RUN, valid_s1,
		"issued read not followed by a write-back stage")

endmodule

// ----- tb/allocation_bitmap_checker.sv -----
// result checker for the allocation bitmap store: bitmap prediction and word compare
`timescale 1ns / 1ps

module allocation_bitmap_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [abs_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [abs_pkg::MODE_W-1:0]     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [abs_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic [0:0]                     m_tuser,
	input  logic                           cfg_wen,
	input  logic [abs_pkg::MAP_SIZE_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             pending
);
	import abs_pkg::*;

	logic [MAP_BITS-1:0]   alloc_map;
	logic [MAP_SIZE_W-1:0] map_size;
	res_t                  expected_outcomes[$];
	res_t                  want;
	req_t                  incoming;

	function automatic res_t apply_request(input req_t r);
		res_t o;
		int   lim;
		int   first;
		int   run;
		o = '0;
		lim = (map_size < MAP_BITS) ? int'(map_size) : MAP_BITS;
		first = int'(r.index);
		run = int'(r.length);
		case (r.mode)
			MODE_SET_BIT, MODE_CLEAR_BIT, MODE_WRITE_BIT, MODE_READ_BIT: begin
				if (first >= lim) begin
					o.status = 1'b1;
				end else if (r.mode == MODE_READ_BIT) begin
					o.read_bit = alloc_map[first];
				end else begin
					alloc_map[first] = (r.mode == MODE_SET_BIT) ||
						(r.mode == MODE_WRITE_BIT && r.bit_value);
				end
			end
			MODE_SET_RANGE, MODE_CLEAR_RANGE: begin
				if (first > lim || run > lim - first) begin
					o.status = 1'b1;
				end else begin
					for (int i = first; i < first + run; i++)
						alloc_map[i] = (r.mode == MODE_SET_RANGE);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_map = '0;
			map_size = MAP_SIZE_RST;
			expected_outcomes.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_outcomes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word, status %0d read_bit %0d",
						$time, m_tuser[0], m_tdata[0]);
				end else begin
					want = expected_outcomes.pop_front();
					if (m_tuser[0] !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_tuser[0]);
					end
					if (m_tdata[0] !== want.read_bit) begin
						fail_count++;
						$display("%0t: read_bit expected %0d actual %0d",
							$time, want.read_bit, m_tdata[0]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				incoming.mode = s_tuser;
				incoming.index = s_tdata[INDEX_W-1:0];
				incoming.length = s_tdata[INDEX_W +: LENGTH_W];
				incoming.bit_value = s_tdata[INDEX_W + LENGTH_W];
				expected_outcomes.push_back(apply_request(incoming));
			end
			if (cfg_wen)
				map_size = cfg_wdata;
			pending = expected_outcomes.size();
		end
	end

endmodule

// ----- tb/tb_allocation_bitmap_store.sv -----
// testbench top for the allocation bitmap store: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_allocation_bitmap_store;
	import abs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RESERVED_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RESERVED_HI = 3'd7;
	localparam logic [MODE_W-1:0] BIT_OPS[4] =
		'{MODE_SET_BIT, MODE_CLEAR_BIT, MODE_WRITE_BIT, MODE_READ_BIT};

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [MODE_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_wen = 1'b0;
	logic [MAP_SIZE_W-1:0] cfg_wdata = '0;

	int          fail_count;
	int          pending;
	int          src_idle = 0;
	int          snk_idle = 0;
	int unsigned cur_limit = LIMIT_RST;

	allocation_bitmap_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	allocation_bitmap_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	initial begin
		#10_000_000;
		$display("tb_allocation_bitmap_store NOT OK");
		$finish;
	end

	task automatic send_request(input logic [MODE_W-1:0] mode, input int unsigned index,
		input int unsigned length, input logic bit_value);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {{(S_DATA_W - INDEX_W - LENGTH_W - 1){1'b0}}, bit_value,
			length[LENGTH_W-1:0], index[INDEX_W-1:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_map_size(input int unsigned value);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= value[MAP_SIZE_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_limit = (value < MAP_BITS) ? value : MAP_BITS;
	endtask

	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		int unsigned room;
		r.bit_value = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 5)
			r.mode = pick[0] ? MODE_RESERVED_LO : MODE_RESERVED_HI;
		else if (pick < 60)
			r.mode = BIT_OPS[$urandom_range(3)];
		else
			r.mode = ($urandom_range(1) != 0) ? MODE_SET_RANGE : MODE_CLEAR_RANGE;
		pick = $urandom_range(99);
		if (pick < 80 && cur_limit > 0)
			r.index = INDEX_W'($urandom_range(cur_limit - 1));
		else if (pick < 90)
			r.index = INDEX_W'(cur_limit + $urandom_range(4) - 2);
		else
			r.index = INDEX_W'($urandom);
		room = (r.index <= cur_limit) ? cur_limit - r.index : 0;
		pick = $urandom_range(99);
		// runs mostly short so a full-map walk stays rare
		if (pick < 70)
			r.length = LENGTH_W'($urandom_range((room < 40) ? room : 40));
		else if (pick < 85)
			r.length = LENGTH_W'($urandom_range(room));
		else if (pick < 95)
			r.length = LENGTH_W'(room + $urandom_range(1));
		else
			r.length = LENGTH_W'($urandom_range(65536));
		return r;
	endfunction

	task automatic run_random(input int count, input bit with_pause);
		req_t r;
		for (int i = 0; i < count; i++) begin
			if (with_pause && i == count / 2)
				drain();
			r = random_request();
			send_request(r.mode, r.index, r.length, r.bit_value);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		src_idle = 9;
		snk_idle = 68;

		send_request(MODE_SET_BIT, 0, 0, 1'b0);
		send_request(MODE_SET_BIT, 4095, 0, 1'b0);
		send_request(MODE_READ_BIT, 0, 0, 1'b0);
		send_request(MODE_READ_BIT, 4095, 0, 1'b0);
		send_request(MODE_READ_BIT, 1, 0, 1'b0);
		send_request(MODE_CLEAR_BIT, 0, 0, 1'b1);
		send_request(MODE_READ_BIT, 0, 0, 1'b0);
		send_request(MODE_WRITE_BIT, 7, 0, 1'b1);
		send_request(MODE_READ_BIT, 7, 0, 1'b0);
		// writing zero has to clear the bit
		send_request(MODE_WRITE_BIT, 7, 0, 1'b0);
		send_request(MODE_READ_BIT, 7, 0, 1'b0);
		send_request(MODE_SET_BIT, 4096, 0, 1'b0);
		send_request(MODE_WRITE_BIT, 65535, 65536, 1'b1);
		send_request(MODE_READ_BIT, 65535, 0, 1'b1);
		send_request(MODE_SET_RANGE, 3, 21, 1'b0);
		send_request(MODE_READ_BIT, 10, 0, 1'b0);
		send_request(MODE_CLEAR_RANGE, 5, 3, 1'b1);
		send_request(MODE_READ_BIT, 6, 0, 1'b0);
		send_request(MODE_SET_RANGE, 4096, 0, 1'b0);
		send_request(MODE_SET_RANGE, 4097, 0, 1'b0);
		send_request(MODE_SET_RANGE, 4095, 2, 1'b0);
		send_request(MODE_CLEAR_RANGE, 65535, 65536, 1'b1);
		send_request(MODE_SET_RANGE, 0, 4096, 1'b0);
		send_request(MODE_CLEAR_RANGE, 8, 4080, 1'b0);
		send_request(MODE_READ_BIT, 4090, 0, 1'b0);
		send_request(MODE_RESERVED_LO, 12, 5, 1'b1);
		send_request(MODE_RESERVED_HI, 65535, 65536, 1'b1);
		run_random(110, 1'b1);

		src_idle = 68;
		snk_idle = 9;
		set_map_size(0);
		run_random(25, 1'b0);
		// above capacity, clamps to the full map
		set_map_size(8191);
		run_random(40, 1'b0);
		set_map_size(100);
		run_random(90, 1'b0);

		src_idle = 0;
		snk_idle = 0;
		set_map_size(1);
		run_random(25, 1'b0);
		set_map_size($urandom_range(4095, 2));
		run_random(90, 1'b0);
		set_map_size(4096);
		run_random(40, 1'b0);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_allocation_bitmap_store OK");
		else
			$display("tb_allocation_bitmap_store NOT OK");
		$finish;
	end

endmodule

// ----- allocation_bitmap_store.f -----
+incdir+hdl
hdl/abs_pkg.sv
hdl/abs_ram.sv
hdl/abs_ctrl.sv
hdl/allocation_bitmap_store.sv
tb/allocation_bitmap_checker.sv
tb/tb_allocation_bitmap_store.sv
